// ===== rtl/rmf_pkg.sv =====
// Shared types, sizes and register codes for the relaxed 3x3 median filter.
package rmf_pkg;

	localparam int MAX_WIDTH = 1024;

	localparam int PIX_W      = 8;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = 16;
	localparam int WIDTH_W    = 11;
	localparam int RANK_W     = 4;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int TAPS        = 9;
	localparam int MEDIAN_RANK = 4;
	localparam int SORT_CELLS  = TAPS - 1;
	localparam int STEP_W      = $clog2(TAPS);

	localparam int OUT_TDATA_W = ((PIX_W + ROW_W + COL_W + 7) / 8) * 8;

	localparam logic [RANK_W-1:0]  LOWER_RANK_RESET   = RANK_W'(3);
	localparam logic [RANK_W-1:0]  UPPER_RANK_RESET   = RANK_W'(7);
	localparam logic [WIDTH_W-1:0] IMAGE_WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [ROW_W-1:0]   IMAGE_HEIGHT_RESET = ROW_W'(1024);

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_LOWER_RANK   = 2'd0,
		REG_UPPER_RANK   = 2'd1,
		REG_IMAGE_WIDTH  = 2'd2,
		REG_IMAGE_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t [TAPS-1:0] taps;
		pixel_t            centre;
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
	} sort_word_t;

endpackage

// ===== rtl/rmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rmf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rmf_window.sv =====
// Raster counters, two line stores and the 3x3 window that feed the sort chain.
module rmf_window (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [rmf_pkg::WIDTH_W-1:0]  image_width,
	input  logic [rmf_pkg::ROW_W-1:0]    image_height,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  rmf_pkg::pixel_t              in_pixel,
	output logic                         out_valid,
	input  logic                         out_ready,
	output rmf_pkg::sort_word_t          out_word
);

	logic [rmf_pkg::COL_W-1:0] col_q;
	logic [rmf_pkg::ROW_W-1:0] row_q;
	logic [rmf_pkg::COL_W:0]   eff_w;
	logic [rmf_pkg::ROW_W-1:0] eff_h;
	logic [rmf_pkg::COL_W:0]   col_inc;
	logic [rmf_pkg::ROW_W:0]   row_inc;
	logic                      accept;
	logic                      leave;
	logic                      hit;

	logic                      valid_s1;
	logic                      hit_s1;
	logic                      byp_s1;
	rmf_pkg::pixel_t           pix_s1;
	rmf_pkg::pixel_t           byp_up_s1;
	rmf_pkg::pixel_t           byp_mid_s1;
	logic [rmf_pkg::COL_W-1:0] col_s1;
	logic [rmf_pkg::ROW_W-1:0] row_s1;

	rmf_pkg::pixel_t           rd_up;
	rmf_pkg::pixel_t           rd_mid;
	rmf_pkg::pixel_t           up;
	rmf_pkg::pixel_t           mid;
	rmf_pkg::pixel_t [5:0]     win_q;

	always_comb begin
		if (image_width == '0) begin
			eff_w = (rmf_pkg::COL_W + 1)'(1);
		end else if (int'(image_width) > rmf_pkg::MAX_WIDTH) begin
			eff_w = (rmf_pkg::COL_W + 1)'(rmf_pkg::MAX_WIDTH);
		end else begin
			eff_w = (rmf_pkg::COL_W + 1)'(image_width);
		end
		eff_h = (image_height == '0) ? rmf_pkg::ROW_W'(1) : image_height;
	end

	assign col_inc = {1'b0, col_q} + (rmf_pkg::COL_W + 1)'(1);
	assign row_inc = {1'b0, row_q} + (rmf_pkg::ROW_W + 1)'(1);
	assign hit = (col_q >= rmf_pkg::COL_W'(2)) && ({1'b0, col_q} < eff_w) &&
		(row_q >= rmf_pkg::ROW_W'(2)) && (row_q < eff_h);

	assign in_ready  = !valid_s1 || !hit_s1 || out_ready;
	assign accept    = in_valid && in_ready;
	assign leave     = valid_s1 && in_ready;
	assign out_valid = valid_s1 && hit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_inc >= eff_w) begin
				col_q <= '0;
				row_q <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[rmf_pkg::ROW_W-1:0];
			end else begin
				col_q <= col_inc[rmf_pkg::COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			hit_s1   <= 1'b0;
			byp_s1   <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= accept;
			hit_s1   <= hit;
			byp_s1   <= leave && (col_s1 == col_q);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1     <= in_pixel;
			col_s1     <= col_q;
			row_s1     <= row_q;
			byp_up_s1  <= mid;
			byp_mid_s1 <= pix_s1;
		end
	end

	// forward the word written at the same edge as the read of the same column
	assign up  = byp_s1 ? byp_up_s1 : rd_up;
	assign mid = byp_s1 ? byp_mid_s1 : rd_mid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (leave) begin
			win_q <= {pix_s1, mid, up, win_q[5:3]};
		end
	end

	rmf_ram #(
		.WIDTH(rmf_pkg::PIX_W),
		.DEPTH(rmf_pkg::MAX_WIDTH)
	) u_line_upper (
		.clk  (clk),
		.we   (leave),
		.waddr(col_s1),
		.wdata(mid),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_up)
	);

	rmf_ram #(
		.WIDTH(rmf_pkg::PIX_W),
		.DEPTH(rmf_pkg::MAX_WIDTH)
	) u_line_middle (
		.clk  (clk),
		.we   (leave),
		.waddr(col_s1),
		.wdata(pix_s1),
		.re   (accept),
		.raddr(col_q),
		.rdata(rd_mid)
	);

	always_comb begin
		out_word.taps   = {pix_s1, mid, up, win_q};
		out_word.centre = win_q[4];
		out_word.row    = row_s1 - rmf_pkg::ROW_W'(1);
		out_word.col    = col_s1 - rmf_pkg::COL_W'(1);
	end

endmodule

// ===== rtl/rmf_sort_cell.sv =====
// One insertion-sort cell: places the tap at position step into the sorted prefix below it.
module rmf_sort_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [rmf_pkg::STEP_W-1:0]  step,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  rmf_pkg::sort_word_t         in_word,
	output logic                        out_valid,
	input  logic                        out_ready,
	output rmf_pkg::sort_word_t         out_word
);

	logic                       valid_q;
	rmf_pkg::sort_word_t        word_q;
	rmf_pkg::sort_word_t        nxt;
	rmf_pkg::pixel_t            x;
	logic [rmf_pkg::TAPS-1:0]   le;

	always_comb begin
		x = in_word.taps[step];
		for (int j = 0; j < rmf_pkg::TAPS; j++) begin
			le[j] = (rmf_pkg::STEP_W'(j) < step) && (in_word.taps[j] <= x);
		end
		nxt = in_word;
		nxt.taps[0] = le[0] ? in_word.taps[0] : x;
		for (int j = 1; j < rmf_pkg::TAPS; j++) begin
			if (rmf_pkg::STEP_W'(j) > step) begin
				nxt.taps[j] = in_word.taps[j];
			end else if (le[j]) begin
				nxt.taps[j] = in_word.taps[j];
			end else if (le[j-1]) begin
				nxt.taps[j] = x;
			end else begin
				nxt.taps[j] = in_word.taps[j-1];
			end
		end
	end

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_word  = word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			word_q <= nxt;
		end
	end

endmodule

// ===== rtl/relaxed_median_filter_3x3.sv =====
// Top level of the relaxed 3x3 median filter: config registers, window, sort chain, output.
//
// Pixels arrive on s_axis in raster order, one 8-bit gray level per word.
// Each accepted pixel completes the 3x3 window of the pixel one row up and one
// column left; for interior pixels one word leaves on m_axis carrying the
// filtered level, its row and column, and in tuser whether the centre was kept.
// Border pixels produce no output word.
// Registers are written through cfg (addr 0 lower_rank, 1 upper_rank,
// 2 image_width, 3 image_height); write them only while the stream is idle.
// Throughput: one pixel per cycle while m_axis accepts, set by the line stores
// (one read and one write per cycle) and the eight sort cells (one insertion
// per cell per cycle). The output word passes the window stage, which loads on
// the accepting edge, then the eight sort cells and the output register.
// When m_axis stalls, the pipeline fills its empty stages, then s_axis_tready
// drops; nothing is lost. Reset clears counters, window and all valid flags and
// restores register defaults; line store contents stay undefined until written.
module relaxed_median_filter_3x3 (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [rmf_pkg::PIX_W-1:0]          s_axis_tdata,  // pixel_in
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [rmf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // pixel_out, out_row, out_col
	output logic                               m_axis_tuser,  // centre_kept
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rmf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [rmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [rmf_pkg::RANK_W-1:0]  lower_rank_q;
	logic [rmf_pkg::RANK_W-1:0]  upper_rank_q;
	logic [rmf_pkg::WIDTH_W-1:0] image_width_q;
	logic [rmf_pkg::ROW_W-1:0]   image_height_q;

	logic [rmf_pkg::SORT_CELLS:0] cv;
	logic [rmf_pkg::SORT_CELLS:0] cr;
	rmf_pkg::sort_word_t          cw [rmf_pkg::SORT_CELLS+1];

	rmf_pkg::sort_word_t          last;
	logic [rmf_pkg::RANK_W-1:0]   hi;
	logic                         kept;
	logic                         m_valid_q;
	rmf_pkg::pixel_t              pix_q;
	logic [rmf_pkg::ROW_W-1:0]    row_q;
	logic [rmf_pkg::COL_W-1:0]    col_q;
	logic                         kept_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_rank_q   <= rmf_pkg::LOWER_RANK_RESET;
			upper_rank_q   <= rmf_pkg::UPPER_RANK_RESET;
			image_width_q  <= rmf_pkg::IMAGE_WIDTH_RESET;
			image_height_q <= rmf_pkg::IMAGE_HEIGHT_RESET;
		end else if (cfg_valid) begin
			case (cfg_addr)
				rmf_pkg::REG_LOWER_RANK: begin
					lower_rank_q <= cfg_data[rmf_pkg::RANK_W-1:0];
				end
				rmf_pkg::REG_UPPER_RANK: begin
					upper_rank_q <= cfg_data[rmf_pkg::RANK_W-1:0];
				end
				rmf_pkg::REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_data[rmf_pkg::WIDTH_W-1:0];
				end
				rmf_pkg::REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_data[rmf_pkg::ROW_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	rmf_window u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.image_width (image_width_q),
		.image_height(image_height_q),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.in_pixel    (s_axis_tdata),
		.out_valid   (cv[0]),
		.out_ready   (cr[0]),
		.out_word    (cw[0])
	);

	for (genvar g = 0; g < rmf_pkg::SORT_CELLS; g++) begin : g_cell
		rmf_sort_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.step     (rmf_pkg::STEP_W'(g + 1)),
			.in_valid (cv[g]),
			.in_ready (cr[g]),
			.in_word  (cw[g]),
			.out_valid(cv[g+1]),
			.out_ready(cr[g+1]),
			.out_word (cw[g+1])
		);
	end

	assign last = cw[rmf_pkg::SORT_CELLS];

	always_comb begin
		hi = (upper_rank_q > rmf_pkg::RANK_W'(rmf_pkg::TAPS - 1)) ?
			rmf_pkg::RANK_W'(rmf_pkg::TAPS - 1) : upper_rank_q;
		kept = 1'b0;
		for (int k = 0; k < rmf_pkg::TAPS; k++) begin
			if ((lower_rank_q <= rmf_pkg::RANK_W'(k)) && (rmf_pkg::RANK_W'(k) <= hi) &&
				(last.taps[k] == last.centre)) begin
				kept = 1'b1;
			end
		end
	end

	assign cr[rmf_pkg::SORT_CELLS] = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cr[rmf_pkg::SORT_CELLS]) begin
			m_valid_q <= cv[rmf_pkg::SORT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (cr[rmf_pkg::SORT_CELLS] && cv[rmf_pkg::SORT_CELLS]) begin
			pix_q  <= kept ? last.centre : last.taps[rmf_pkg::MEDIAN_RANK];
			row_q  <= last.row;
			col_q  <= last.col;
			kept_q <= kept;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = rmf_pkg::OUT_TDATA_W'({col_q, row_q, pix_q});
	assign m_axis_tuser  = kept_q;

endmodule

// ===== rtl/rmf_checker.sv =====
// Port-level checks for the relaxed 3x3 median filter, bound to the top level.
module rmf_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [rmf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	input logic                               m_axis_tuser
);

	localparam int ROW_LO = rmf_pkg::PIX_W;
	localparam int ROW_HI = rmf_pkg::PIX_W + rmf_pkg::ROW_W - 1;
	localparam int COL_LO = ROW_HI + 1;
	localparam int COL_HI = COL_LO + rmf_pkg::COL_W - 1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("output word changed while stalled");

	a_reset_idle: assert property (@(posedge clk)
		!arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[ROW_HI:ROW_LO] != '0) &&
			(m_axis_tdata[COL_HI:COL_LO] != '0) &&
			(m_axis_tdata[COL_HI:COL_LO] != '1))
		else $error("output position on the image border");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[rmf_pkg::OUT_TDATA_W-1:COL_HI+1] == '0))
		else $error("nonzero pad bits in output word");

endmodule

bind relaxed_median_filter_3x3 rmf_checker u_rmf_checker (.*);

// ===== test/relaxed_median_filter_3x3_tb.sv =====
// Self-checking testbench for the relaxed 3x3 median filter: directed frames, back-pressure, random frames.
module relaxed_median_filter_3x3_tb;
	import rmf_pkg::*;

	localparam int ROW_LSB      = PIX_W;
	localparam int COL_LSB      = PIX_W + ROW_W;
	localparam int PAD_LSB      = COL_LSB + COL_W;
	localparam int DRAIN_CYCLES = 20;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 5000;

	typedef enum int {PIX_FULL, PIX_FEW, PIX_EDGE} pix_style_t;

	typedef struct packed {
		pixel_t           level;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             kept;
	} filtered_px_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [PIX_W-1:0]       s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	cfg_reg_t               cfg_addr = REG_LOWER_RANK;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	int unsigned src_idle_pct = 30;
	int unsigned snk_idle_pct = 58;
	int unsigned pixels_sent = 0;
	int unsigned fail_count = 0;
	bit          hold_start = 1'b0;
	bit          hold_seen = 1'b0;
	int unsigned hold_left = 0;

	filtered_px_t expected_px[$];

	logic [RANK_W-1:0]  lo_rank = LOWER_RANK_RESET;
	logic [RANK_W-1:0]  up_rank = UPPER_RANK_RESET;
	logic [WIDTH_W-1:0] width_reg = IMAGE_WIDTH_RESET;
	logic [ROW_W-1:0]   height_reg = IMAGE_HEIGHT_RESET;
	pixel_t             upper_line[MAX_WIDTH];
	pixel_t             middle_line[MAX_WIDTH];
	pixel_t             win[6];
	int unsigned        col_cnt = 0;
	int unsigned        row_cnt = 0;

	relaxed_median_filter_3x3 i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_addr      (cfg_addr),
		.cfg_data      (cfg_data)
	);

	initial forever #5 clk = ~clk;

	function automatic int unsigned frame_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned frame_height();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic void filter_pixel(pixel_t cur);
		int unsigned w, h, c, r, idx, hi;
		int i, j;
		pixel_t up, mid, centre, x;
		pixel_t v[9];
		logic kept;
		filtered_px_t res;
		w = frame_width();
		h = frame_height();
		c = col_cnt;
		r = row_cnt;
		idx = (c < MAX_WIDTH) ? c : MAX_WIDTH - 1;
		up = upper_line[idx];
		mid = middle_line[idx];
		if (c >= 2 && c < w && r >= 2 && r < h) begin
			centre = win[4];
			for (i = 0; i < 6; i++) v[i] = win[i];
			v[6] = up;
			v[7] = mid;
			v[8] = cur;
			for (i = 1; i < 9; i++) begin
				x = v[i];
				j = i - 1;
				while (j >= 0 && v[j] > x) begin
					v[j + 1] = v[j];
					j--;
				end
				v[j + 1] = x;
			end
			hi = (up_rank > 8) ? 8 : up_rank;
			kept = 1'b0;
			for (i = lo_rank; i <= int'(hi); i++)
				if (v[i] == centre) kept = 1'b1;
			res.level = kept ? centre : v[MEDIAN_RANK];
			res.row = ROW_W'(r - 1);
			res.col = COL_W'(c - 1);
			res.kept = kept;
			expected_px.push_back(res);
		end
		upper_line[idx] = mid;
		middle_line[idx] = cur;
		win[0] = win[3];
		win[1] = win[4];
		win[2] = win[5];
		win[3] = up;
		win[4] = mid;
		win[5] = cur;
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) r = 0;
		end
		col_cnt = c;
		row_cnt = r;
	endfunction

	function automatic void check_pixel();
		filtered_px_t want;
		if (expected_px.size() == 0) begin
			$error("unexpected output word: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
			fail_count++;
			return;
		end
		want = expected_px.pop_front();
		if (m_axis_tdata[ROW_LSB-1:0] !== want.level) begin
			$error("pixel_out: expected %0d, actual %0d", want.level, m_axis_tdata[ROW_LSB-1:0]);
			fail_count++;
		end
		if (m_axis_tdata[COL_LSB-1:ROW_LSB] !== want.row) begin
			$error("out_row: expected %0d, actual %0d", want.row, m_axis_tdata[COL_LSB-1:ROW_LSB]);
			fail_count++;
		end
		if (m_axis_tdata[PAD_LSB-1:COL_LSB] !== want.col) begin
			$error("out_col: expected %0d, actual %0d", want.col, m_axis_tdata[PAD_LSB-1:COL_LSB]);
			fail_count++;
		end
		if (m_axis_tdata[OUT_TDATA_W-1:PAD_LSB] !== '0) begin
			$error("tdata padding: expected 0, actual %h", m_axis_tdata[OUT_TDATA_W-1:PAD_LSB]);
			fail_count++;
		end
		if (m_axis_tuser !== want.kept) begin
			$error("centre_kept: expected %0d, actual %0d", want.kept, m_axis_tuser);
			fail_count++;
		end
	endfunction

	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready) check_pixel();
		if (hold_seen != hold_start) begin
			hold_seen <= hold_start;
			hold_left <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin : watchdog
		int unsigned stalled;
		stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			    (cfg_valid && cfg_ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	function automatic pixel_t make_pixel(pix_style_t style);
		case (style)
			PIX_FEW:  return pixel_t'($urandom_range(3));
			PIX_EDGE: return $urandom_range(1) ? 8'hFF : 8'h00;
			default:  return pixel_t'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_rank();
		logic [CFG_DATA_W-1:0] value;
		value = CFG_DATA_W'($urandom);
		case ($urandom_range(4))
			0:       value[RANK_W-1:0] = '0;
			1:       value[RANK_W-1:0] = RANK_W'(8);
			2:       value[RANK_W-1:0] = RANK_W'($urandom_range(9, 15));
			default: value[RANK_W-1:0] = RANK_W'($urandom_range(8));
		endcase
		return value;
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_width();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 8) return CFG_DATA_W'($urandom_range(2));
		if (roll < 14) return CFG_DATA_W'($urandom_range(17, 40));
		return CFG_DATA_W'($urandom_range(3, 16));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_height();
		if ($urandom_range(99) < 8) return CFG_DATA_W'($urandom_range(2));
		return CFG_DATA_W'($urandom_range(3, 8));
	endfunction

	task automatic send_pixel(pixel_t p);
		if ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= p;
		do @(posedge clk); while (!s_axis_tready);
		pixels_sent++;
		filter_pixel(p);
	endtask

	task automatic send_frame(pix_style_t style);
		repeat (frame_width() * frame_height()) send_pixel(make_pixel(style));
	endtask

	task automatic finish_frame(pix_style_t style);
		while (col_cnt != 0 || row_cnt != 0) send_pixel(make_pixel(style));
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_px.size() != 0) @(posedge clk);
		// let border pixels still in the pipeline drain
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_addr <= sel;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (sel)
			REG_LOWER_RANK:   lo_rank = value[RANK_W-1:0];
			REG_UPPER_RANK:   up_rank = value[RANK_W-1:0];
			REG_IMAGE_WIDTH:  width_reg = value[WIDTH_W-1:0];
			REG_IMAGE_HEIGHT: height_reg = value[ROW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] up,
	                         logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		settle();
		write_reg(REG_LOWER_RANK, lo);
		write_reg(REG_UPPER_RANK, up);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		repeat (6) send_pixel(make_pixel(PIX_FULL));
	endtask

	task automatic test_tiny_frames();
		// shrink the frame mid-row; counters wrap and nothing comes out
		configure(LOWER_RANK_RESET, UPPER_RANK_RESET, 0, 0);
		repeat (3) send_pixel(make_pixel(PIX_FULL));
		configure(LOWER_RANK_RESET, UPPER_RANK_RESET, 2, 2);
		send_frame(PIX_EDGE);
		send_frame(PIX_EDGE);
	endtask

	task automatic test_extreme_levels();
		pixel_t levels[12];
		levels = '{8'hFF, 8'hFF, 8'hFF,
		           8'hFF, 8'h00, 8'hFF,
		           8'hFF, 8'hFF, 8'hFF,
		           8'h00, 8'h00, 8'h00};
		configure(LOWER_RANK_RESET, UPPER_RANK_RESET, 3, 4);
		foreach (levels[i]) send_pixel(levels[i]);
	endtask

	task automatic test_height_change_mid_image();
		configure(0, 8, 3, 16'hFFFF);
		repeat (18) send_pixel(make_pixel(PIX_FEW));
		configure(9, 15, 3, 3);
		finish_frame(PIX_FEW);
		send_frame(PIX_FEW);
	endtask

	task automatic test_output_backpressure();
		configure(LOWER_RANK_RESET, UPPER_RANK_RESET, 8, 6);
		hold_start <= ~hold_start;
		send_frame(PIX_FULL);
		send_frame(PIX_FEW);
	endtask

	task automatic test_widest_row();
		configure(pick_rank(), pick_rank(), 16'h07FF, 1);
		send_frame(PIX_FULL);
	endtask

	task automatic test_random_frames(int unsigned count, int unsigned src_pct,
	                                  int unsigned snk_pct);
		int unsigned target;
		pix_style_t style;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		target = pixels_sent + count;
		while (pixels_sent < target) begin
			configure(pick_rank(), pick_rank(), pick_width(), pick_height());
			style = pix_style_t'($urandom_range(PIX_EDGE));
			repeat ($urandom_range(1, 3)) send_frame(style);
		end
	endtask

	initial begin
		foreach (win[i]) win[i] = '0;
		foreach (upper_line[i]) begin
			upper_line[i] = '0;
			middle_line[i] = '0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_tiny_frames();
		test_extreme_levels();
		test_height_change_mid_image();
		test_output_backpressure();
		test_widest_row();
		test_random_frames(150, 30, 58);
		test_random_frames(150, 58, 30);
		test_random_frames(150, 0, 0);
		settle();
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
